/* hdl/blsd_pkg.sv */
// ----------------------------------------------------------------------------
// Bicolor LED scan driver package
// Shared widths, codes, queue entry type and line lookup functions.
// ----------------------------------------------------------------------------
package blsd_pkg;

  localparam int LedCount   = 10;
  localparam int IdxW       = 4;
  localparam int LineW      = 5;
  localparam int LineSelW   = 3;
  localparam int ModeW      = 2;
  localparam int HalfW      = 15;
  localparam int TickW      = 16;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [HalfW-1:0] HalfReset = HalfW'(500);

  localparam logic [ModeW-1:0] ModeOff   = 2'd0;
  localparam logic [ModeW-1:0] ModeOn    = 2'd1;
  localparam logic [ModeW-1:0] ModeBlink = 2'd2;

  localparam logic ColorGreen = 1'b0;
  localparam logic ColorRed   = 1'b1;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             color;
  } led_setting_t;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] idx;
    led_setting_t    setting;
  } q_entry_t;

  function automatic logic [LineSelW-1:0] green_line(input logic [IdxW-1:0] idx);
    logic [LineSelW-1:0] sel;
    unique case (idx)
      4'd0:    sel = 3'd0;
      4'd1:    sel = 3'd1;
      4'd2:    sel = 3'd2;
      4'd3:    sel = 3'd1;
      4'd4:    sel = 3'd0;
      4'd5:    sel = 3'd0;
      4'd6:    sel = 3'd3;
      4'd7:    sel = 3'd2;
      4'd8:    sel = 3'd1;
      4'd9:    sel = 3'd0;
      default: sel = 3'd0;
    endcase
    return sel;
  endfunction

  function automatic logic [LineSelW-1:0] red_line(input logic [IdxW-1:0] idx);
    logic [LineSelW-1:0] sel;
    unique case (idx)
      4'd0:    sel = 3'd1;
      4'd1:    sel = 3'd2;
      4'd2:    sel = 3'd3;
      4'd3:    sel = 3'd3;
      4'd4:    sel = 3'd2;
      4'd5:    sel = 3'd3;
      4'd6:    sel = 3'd4;
      4'd7:    sel = 3'd4;
      4'd8:    sel = 3'd4;
      4'd9:    sel = 3'd4;
      default: sel = 3'd1;
    endcase
    return sel;
  endfunction

endpackage

/* hdl/bicolor_led_scan_driver_unit.sv */
// ----------------------------------------------------------------------------
// Bicolor LED scan driver
// Drives ten two-colour LEDs over five shared lines, one LED per tick.
// ----------------------------------------------------------------------------
// Items arrive on a valid/ready input channel. A tick item (kind 0) advances
// the blink counter and drives the next LED in the scan; a write item (kind 1)
// stores one LED's mode and colour and gives no result. Writes to an LED index
// of ten or more are accepted and discarded.
// Each tick gives one result on the valid/ready output channel: the LED
// index, the line enables, the line levels and the blink phase.
// A classified item waits in a two-entry queue; the back end takes one item
// per cycle unless an untaken result stalls a tick, so the block sustains
// one transfer per cycle while results are taken; results are registered.
// When the receiver stalls, the held result stays put and the queue fills;
// input ready falls once both queue entries are taken.
// The user must write the blink half period register with cfg_we_i only while
// idle; the block does not check it. Reset empties the queue, clears counters,
// turns all LEDs off (green), half period 500 ticks; no clearing pass needed.
// ----------------------------------------------------------------------------
module bicolor_led_scan_driver_unit import blsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [HalfW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             kind_i,
  input  logic [IdxW-1:0]  led_index_i,
  input  logic [ModeW-1:0] led_mode_i,
  input  logic             led_color_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IdxW-1:0]  scanned_led_o,
  output logic [LineW-1:0] line_enable_o,
  output logic [LineW-1:0] line_level_o,
  output logic             blink_phase_o
);

  logic     push;
  logic     push_ready;
  q_entry_t push_entry;
  logic     pop_valid;
  logic     pop;
  q_entry_t pop_entry;

  blsd_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .led_index_i  (led_index_i),
    .led_mode_i   (led_mode_i),
    .led_color_i  (led_color_i),
    .push_o       (push),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  blsd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry),
    .pop_i        (pop)
  );

  blsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pop_valid_i   (pop_valid),
    .pop_entry_i   (pop_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .scanned_led_o (scanned_led_o),
    .line_enable_o (line_enable_o),
    .line_level_o  (line_level_o),
    .blink_phase_o (blink_phase_o)
  );

endmodule

/* hdl/blsd_front.sv */
// ----------------------------------------------------------------------------
// Bicolor LED scan driver front end
// Accepts input items, classifies them and drops writes to absent LEDs.
// ----------------------------------------------------------------------------
module blsd_front import blsd_pkg::*; (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            kind_i,
  input  logic [IdxW-1:0] led_index_i,
  input  logic [ModeW-1:0] led_mode_i,
  input  logic            led_color_i,
  output logic            push_o,
  output q_entry_t        push_entry_o,
  input  logic            push_ready_i
);

  logic keep;

  always_comb begin
    push_entry_o.op            = kind_i ? OP_WRITE : OP_TICK;
    push_entry_o.idx           = led_index_i;
    push_entry_o.setting.mode  = led_mode_i;
    push_entry_o.setting.color = led_color_i;
    keep = !kind_i || (led_index_i < IdxW'(LedCount));
  end

  // An ignored write is taken whenever the queue has room and never enters it.
  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i && push_ready_i && keep;

endmodule

/* hdl/blsd_queue.sv */
// ----------------------------------------------------------------------------
// Bicolor LED scan driver queue
// Small first-in first-out store of classified items between front and back.
// ----------------------------------------------------------------------------
module blsd_queue import blsd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_entry_i,
  output logic     push_ready_o,
  output logic     pop_valid_o,
  output q_entry_t pop_entry_o,
  input  logic     pop_i
);

  q_entry_t               mem_q [QueueDepth];
  logic [QPtrW-1:0]       wptr_q, wptr_d;
  logic [QPtrW-1:0]       rptr_q, rptr_d;
  logic [QCntW-1:0]       cnt_q, cnt_d;

  assign push_ready_o = cnt_q != QCntW'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_entry_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_entry_i;
    end
  end

endmodule

/* hdl/blsd_back.sv */
// ----------------------------------------------------------------------------
// Bicolor LED scan driver back end
// Applies LED writes, runs the blink counter and drives one LED per tick.
// ----------------------------------------------------------------------------
module blsd_back import blsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [HalfW-1:0] cfg_wdata_i,
  input  logic             pop_valid_i,
  input  q_entry_t         pop_entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IdxW-1:0]  scanned_led_o,
  output logic [LineW-1:0] line_enable_o,
  output logic [LineW-1:0] line_level_o,
  output logic             blink_phase_o
);

  logic [HalfW-1:0] half_q;
  logic [TickW-1:0] tick_q, tick_d;
  logic             lit_q, lit_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  led_setting_t     led_q [LedCount];

  logic             out_valid_q;
  logic [IdxW-1:0]  out_led_q;
  logic [LineW-1:0] en_q, lvl_q, en_d, lvl_d;

  logic             is_tick;
  logic             tick_go;
  logic [IdxW-1:0]  pos_use;
  led_setting_t     cur;
  logic             on;
  logic [LineW-1:0] g_bit, r_bit;

  assign is_tick = pop_entry_i.op == OP_TICK;
  assign pop_o   = pop_valid_i && (!is_tick || !out_valid_q || out_ready_i);
  assign tick_go = pop_o && is_tick;

  always_comb begin
    tick_d = tick_q + TickW'(1);
    lit_d  = lit_q;
    if (tick_q == {1'b0, half_q}) begin
      lit_d = 1'b1;
    end else if (tick_q >= {half_q, 1'b0}) begin
      lit_d  = 1'b0;
      tick_d = '0;
    end
    pos_use = (pos_q >= IdxW'(LedCount)) ? '0 : pos_q;
    pos_d   = pos_use + IdxW'(1);
    cur     = led_q[pos_use];
    on      = (cur.mode == ModeOn) || ((cur.mode == ModeBlink) && lit_d);
    g_bit   = LineW'(1) << green_line(pos_use);
    r_bit   = LineW'(1) << red_line(pos_use);
    en_d    = g_bit | r_bit;
    lvl_d   = '0;
    if (on) begin
      lvl_d = (cur.color == ColorRed) ? r_bit : g_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q      <= HalfReset;
      tick_q      <= '0;
      lit_q       <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LedCount; i++) begin
        led_q[i] <= '{mode: ModeOff, color: ColorGreen};
      end
    end else begin
      if (cfg_we_i) begin
        half_q <= cfg_wdata_i;
      end
      if (pop_o && !is_tick) begin
        led_q[pop_entry_i.idx] <= pop_entry_i.setting;
      end
      if (tick_go) begin
        tick_q <= tick_d;
        lit_q  <= lit_d;
        pos_q  <= pos_d;
      end
      if (tick_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      out_led_q <= pos_use;
      en_q      <= en_d;
      lvl_q     <= lvl_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scanned_led_o = out_led_q;
  assign line_enable_o = en_q;
  assign line_level_o  = lvl_q;
  assign blink_phase_o = lit_q;

endmodule

/* tb/sv/bicolor_led_scan_driver_unit_tb.sv */
// ----------------------------------------------------------------------------
// Bicolor LED scan driver testbench
// Drives tick and write items into the scan driver through a queued driver,
// predicts every scan result with its own model of the counters and LED
// settings, and checks each result transfer in order. The blink half period
// is changed between drained phases, and both channels stall at random.
// ----------------------------------------------------------------------------
module bicolor_led_scan_driver_unit_tb;
  import blsd_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int LongHold    = 150;
  localparam int DrainCycles = 8;
  localparam int MaxShown    = 10;
  localparam int PhaseItems  = 60;

  localparam logic [LineSelW-1:0] GreenSel [LedCount] =
    '{3'd0, 3'd1, 3'd2, 3'd1, 3'd0, 3'd0, 3'd3, 3'd2, 3'd1, 3'd0};
  localparam logic [LineSelW-1:0] RedSel [LedCount] =
    '{3'd1, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4};

  typedef struct packed {
    op_e              kind;
    logic [IdxW-1:0]  idx;
    logic [ModeW-1:0] mode;
    logic             color;
  } scan_item_t;

  typedef struct packed {
    logic [IdxW-1:0]  led;
    logic [LineW-1:0] enable;
    logic [LineW-1:0] level;
    logic             phase;
  } scan_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic             cfg_we    = 1'b0;
  logic [HalfW-1:0] cfg_wdata = '0;

  logic             tx_valid = 1'b0;
  op_e              tx_kind  = OP_TICK;
  logic [IdxW-1:0]  tx_index = '0;
  logic [ModeW-1:0] tx_mode  = ModeOff;
  logic             tx_color = ColorGreen;
  logic             rx_ready = 1'b0;

  logic             in_ready;
  logic             out_valid;
  logic [IdxW-1:0]  scanned_led;
  logic [LineW-1:0] line_enable;
  logic [LineW-1:0] line_level;
  logic             blink_phase;

  scan_item_t   pending_items[$];
  scan_result_t expected_scans[$];

  logic in_took  = 1'b0;
  logic out_took = 1'b0;
  logic tx_idle  = 1'b0;
  logic rx_idle  = 1'b0;
  logic tx_pause = 1'b0;
  logic rx_hold_req = 1'b0;
  int   tx_gap = 0;
  int   rx_gap = 0;
  int   rx_hold_left = 0;
  int   failures = 0;
  int   quiet_cycles = 0;

  logic [HalfW-1:0] half_m  = HalfReset;
  logic [TickW-1:0] count_m = '0;
  logic             lit_m   = 1'b0;
  logic [IdxW-1:0]  pos_m   = '0;
  led_setting_t     leds_m [LedCount];

  bicolor_led_scan_driver_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (tx_valid),
    .in_ready_o    (in_ready),
    .kind_i        (tx_kind),
    .led_index_i   (tx_index),
    .led_mode_i    (tx_mode),
    .led_color_i   (tx_color),
    .out_valid_o   (out_valid),
    .out_ready_i   (rx_ready),
    .scanned_led_o (scanned_led),
    .line_enable_o (line_enable),
    .line_level_o  (line_level),
    .blink_phase_o (blink_phase)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic predict_scan(input scan_item_t it);
    logic [TickW-1:0] c;
    logic [IdxW-1:0]  p;
    logic             on;
    scan_result_t     r;
    if (it.kind == OP_WRITE) begin
      if (it.idx < LedCount) begin
        leds_m[it.idx] = '{mode: it.mode, color: it.color};
      end
      return;
    end
    c = count_m;
    count_m = c + TickW'(1);
    if (c == TickW'(half_m)) begin
      lit_m = 1'b1;
    end else if (c >= {half_m, 1'b0}) begin
      lit_m = 1'b0;
      count_m = '0;
    end
    p = (pos_m >= LedCount) ? '0 : pos_m;
    on = (leds_m[p].mode == ModeOn) || (leds_m[p].mode == ModeBlink && lit_m);
    r.led = p;
    r.enable = (LineW'(1) << GreenSel[p]) | (LineW'(1) << RedSel[p]);
    r.level = '0;
    if (on) begin
      r.level = (leds_m[p].color == ColorRed) ? (LineW'(1) << RedSel[p])
                                              : (LineW'(1) << GreenSel[p]);
    end
    r.phase = lit_m;
    pos_m = p + IdxW'(1);
    expected_scans.push_back(r);
  endtask

  always @(posedge clk_i) begin
    scan_result_t want;
    scan_item_t   it;
    in_took  <= tx_valid && in_ready;
    out_took <= out_valid && rx_ready;
    if (rst_ni) begin
      if (out_valid && rx_ready) begin
        if (expected_scans.size() == 0) begin
          failures++;
          if (failures <= MaxShown) begin
            $display("unexpected result: led %0d en %b lvl %b phase %b",
                     scanned_led, line_enable, line_level, blink_phase);
          end
        end else begin
          want = expected_scans.pop_front();
          if (want.led !== scanned_led || want.enable !== line_enable ||
              want.level !== line_level || want.phase !== blink_phase) begin
            failures++;
            if (failures <= MaxShown) begin
              $display(
                "mismatch: expected led %0d en %b lvl %b phase %b, got %0d %b %b %b",
                want.led, want.enable, want.level, want.phase,
                scanned_led, line_enable, line_level, blink_phase);
            end
          end
        end
      end
      if (tx_valid && in_ready) begin
        it = '{kind: tx_kind, idx: tx_index, mode: tx_mode, color: tx_color};
        predict_scan(it);
      end
    end
  end

  always @(negedge clk_i) begin
    logic       vld;
    scan_item_t cur;
    vld = tx_valid;
    if (rst_ni) begin
      if (tx_valid && in_took) begin
        vld = 1'b0;
        tx_gap = tx_idle ? $urandom_range(0, 16) : 0;
      end
      if (!vld) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_items.size() > 0 && !tx_pause) begin
          cur = pending_items.pop_front();
          tx_kind  <= cur.kind;
          tx_index <= cur.idx;
          tx_mode  <= cur.mode;
          tx_color <= cur.color;
          vld = 1'b1;
        end
      end
    end
    tx_valid <= vld;
  end

  always @(negedge clk_i) begin
    if (out_took) begin
      rx_gap = rx_idle ? $urandom_range(0, 16) : 0;
    end
    if (rx_hold_req) begin
      rx_hold_left = LongHold;
      rx_hold_req = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      rx_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      rx_ready <= 1'b0;
    end else begin
      rx_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (tx_valid && in_ready) || (out_valid && rx_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void push_tick();
    pending_items.push_back('{kind: OP_TICK, idx: '0, mode: ModeOff, color: ColorGreen});
  endfunction

  function automatic void push_write(input logic [IdxW-1:0] idx,
                                     input logic [ModeW-1:0] mode,
                                     input logic color);
    pending_items.push_back('{kind: OP_WRITE, idx: idx, mode: mode, color: color});
  endfunction

  function automatic void push_random();
    scan_item_t it;
    it.kind  = ($urandom_range(0, 9) < 7) ? OP_TICK : OP_WRITE;
    it.idx   = ($urandom_range(0, 7) == 0) ? IdxW'($urandom_range(10, 15))
                                           : IdxW'($urandom_range(0, 9));
    it.mode  = ModeW'($urandom_range(0, 3));
    it.color = 1'($urandom_range(0, 1));
    pending_items.push_back(it);
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || tx_valid || expected_scans.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_half(input logic [HalfW-1:0] v);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    half_m = v;
  endtask

  task automatic start_phase(input logic [HalfW-1:0] v);
    wait_drained();
    write_half(v);
    tx_idle = ($urandom_range(0, 3) != 0);
    rx_idle = ($urandom_range(0, 3) != 0);
  endtask

  initial begin
    logic [HalfW-1:0] halves [4];
    foreach (leds_m[i]) leds_m[i] = '{mode: ModeOff, color: ColorGreen};
    halves = '{HalfW'(0), HalfW'(1), HalfW'(32767), HalfW'(5)};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (3) push_tick();
    push_write(4'd0, ModeOn, ColorGreen);
    push_write(4'd1, ModeOn, ColorRed);
    push_write(4'd2, ModeBlink, ColorGreen);
    push_write(4'd3, ModeBlink, ColorRed);
    push_write(4'd4, 2'd3, ColorRed);
    push_write(4'd9, ModeOn, ColorRed);
    push_write(4'd10, ModeOn, ColorRed);
    push_write(4'd15, 2'd3, ColorRed);
    repeat (13) push_tick();

    foreach (halves[k]) begin
      start_phase(halves[k]);
      repeat (PhaseItems) push_random();
    end

    // The receiver holds off while the sender offers back-to-back items.
    start_phase(HalfW'(2));
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_req = 1'b1;
    repeat (PhaseItems) push_random();

    // The sender stops mid-phase until every outstanding result has arrived.
    start_phase(HalfW'(3));
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (PhaseItems) push_random();
    while (pending_items.size() > PhaseItems / 2) @(posedge clk_i);
    tx_pause = 1'b1;
    while (tx_valid || expected_scans.size() != 0) @(posedge clk_i);
    tx_pause = 1'b0;

    repeat (5) begin
      start_phase(HalfW'($urandom_range(1, 9)));
      repeat (PhaseItems) push_random();
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (failures == 0 && expected_scans.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
